/* hdl/sst_pkg.sv */
package sst_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_BITS = 32;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_ERASE  = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_GET    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_REJECT = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef struct packed {
		action_t     action;
		logic [31:0] key;
		logic [5:0]  rank;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] found_key;
		logic [6:0]  member_count;
	} rsp_t;

	typedef struct packed {
		logic ins_go;
		logic era_go;
	} cell_ctl_t;

	function automatic logic [KEY_BITS-1:0] to_key(input logic [31:0] k);
		logic [95:0] t;
		t = {64'd0, k};
		return t[KEY_BITS-1:0];
	endfunction

	function automatic logic [31:0] from_key(input logic [KEY_BITS-1:0] k);
		logic [95:0] t;
		t = '0;
		t[KEY_BITS-1:0] = k;
		return t[31:0];
	endfunction

endpackage

/* hdl/sst_cell.sv */
module sst_cell
	import sst_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                capture,
	input  logic [KEY_BITS-1:0] cmp_key,
	input  cell_ctl_t           ctl,
	input  logic [KEY_BITS-1:0] new_key,
	input  logic [KEY_BITS-1:0] left_key,
	input  logic                left_occ,
	input  logic                left_ge,
	input  logic [KEY_BITS-1:0] right_key,
	input  logic                right_occ,
	output logic [KEY_BITS-1:0] key_q,
	output logic                occ_q,
	output logic                ge_s1,
	output logic                eq_s1
);

	logic ge_c;
	logic eq_c;

	// A cell is at or after the insertion point when it is empty or not below the key.
	assign ge_c = !(occ_q && (key_q < cmp_key));
	assign eq_c = occ_q && (key_q == cmp_key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			ge_s1 <= 1'b0;
			eq_s1 <= 1'b0;
		end else begin
			if (capture) begin
				ge_s1 <= ge_c;
				eq_s1 <= eq_c;
			end
			if (ctl.ins_go) begin
				occ_q <= occ_q | left_occ;
			end else if (ctl.era_go && ge_s1) begin
				occ_q <= right_occ;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins_go && ge_s1) begin
			key_q <= left_ge ? left_key : new_key;
		end else if (ctl.era_go && ge_s1) begin
			key_q <= right_key;
		end
	end

endmodule

/* hdl/sorted_set_table_top.sv */
// An accepted request is registered, then its response once the output is free.
// One request is in flight at a time, so a new request is taken only after the last
// has moved on to the response; a stalled response holds off the next request.
// Cells compare all keys in the acceptance cycle and shift when the output is free.
// Reset is asynchronous and active low; it empties the set at once.
module sorted_set_table_top
	import sst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic [KEY_BITS-1:0] key_w [CAPACITY];
	logic [CAPACITY-1:0] occ_w;
	logic [CAPACITY-1:0] ge_w;
	logic [CAPACITY-1:0] eq_w;

	logic                busy_s1;
	action_t             act_s1;
	logic [KEY_BITS-1:0] key_s1;
	logic [5:0]          rank_s1;
	logic [CNT_W-1:0]    count_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic                capture;
	logic [KEY_BITS-1:0] cmp_key;
	logic                go;
	logic                present;
	logic                full;
	logic                rank_ok;
	logic [IDX_W-1:0]    rank_idx;
	logic [15:0]         rank_ext;
	logic [15:0]         count_ext;
	cell_ctl_t           ctl;
	status_t             status_c;
	logic [31:0]         found_c;
	logic [CNT_W-1:0]    count_next;
	logic [15:0]         count_next_ext;

	assign req_ready = !busy_s1;
	assign capture = req_valid && req_ready;
	assign cmp_key = to_key(req.key);

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			sst_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.capture  (capture),
				.cmp_key  (cmp_key),
				.ctl      (ctl),
				.new_key  (key_s1),
				.left_key ((i == 0) ? key_s1 : key_w[(i == 0) ? 0 : i - 1]),
				.left_occ ((i == 0) ? 1'b1 : occ_w[(i == 0) ? 0 : i - 1]),
				.left_ge  ((i == 0) ? 1'b0 : ge_w[(i == 0) ? 0 : i - 1]),
				.right_key((i == CAPACITY - 1) ? key_w[i] :
					key_w[(i == CAPACITY - 1) ? i : i + 1]),
				.right_occ((i == CAPACITY - 1) ? 1'b0 :
					occ_w[(i == CAPACITY - 1) ? i : i + 1]),
				.key_q    (key_w[i]),
				.occ_q    (occ_w[i]),
				.ge_s1    (ge_w[i]),
				.eq_s1    (eq_w[i])
			);
		end
	endgenerate

	assign go = busy_s1 && (!rsp_valid_q || rsp_ready);
	assign present = |eq_w;
	assign full = occ_w[CAPACITY-1];
	assign rank_ext = {10'd0, rank_s1};
	assign count_ext = 16'(count_q);
	assign rank_ok = rank_ext < count_ext;
	assign rank_idx = rank_ext[IDX_W-1:0];

	always_comb begin
		ctl.ins_go = 1'b0;
		ctl.era_go = 1'b0;
		status_c = ST_REJECT;
		found_c = '0;
		count_next = count_q;
		case (act_s1)
			ACT_INSERT: begin
				if (present) begin
					status_c = ST_REJECT;
				end else if (full) begin
					status_c = ST_FULL;
				end else begin
					status_c = ST_OK;
					ctl.ins_go = go;
					count_next = count_q + 1'b1;
				end
			end
			ACT_ERASE: begin
				if (present) begin
					status_c = ST_OK;
					ctl.era_go = go;
					count_next = count_q - 1'b1;
				end
			end
			ACT_QUERY: begin
				status_c = present ? ST_OK : ST_REJECT;
			end
			ACT_GET: begin
				if (rank_ok) begin
					status_c = ST_OK;
					found_c = from_key(key_w[rank_idx]);
				end
			end
			default: begin
				status_c = ST_REJECT;
			end
		endcase
	end

	assign count_next_ext = 16'(count_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (capture) begin
				busy_s1 <= 1'b1;
			end else if (go) begin
				busy_s1 <= 1'b0;
			end
			if (go) begin
				count_q <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			act_s1 <= req.action;
			key_s1 <= cmp_key;
			rank_s1 <= req.rank;
		end
		if (go) begin
			rsp_q.status <= status_c;
			rsp_q.found_key <= found_c;
			rsp_q.member_count <= count_next_ext[6:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

/* hdl/sst_checker.sv */
module sst_checker
	import sst_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("A second request was taken while one was in flight.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(rsp.member_count) <= 32'(CAPACITY)))
		else $error("The member count exceeds the capacity.");

	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status != ST_OK)) |-> (rsp.found_key == 32'd0))
		else $error("A failed request returned a nonzero key.");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
		else $error("A stalled response changed before it was taken.");

endmodule

bind sorted_set_table_top sst_checker u_sst_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
